@@ rtl/spf_pkg.sv @@
package spf_pkg;

  localparam int MIN_PACKET_BYTES = 7;
  localparam int HDR_BYTES        = 6;
  localparam int LEN_LIMIT        = 65542;
  localparam logic [10:0] IDLE_APID  = 11'h7FF;
  localparam logic [1:0]  IDLE_FLAGS = 2'd3;
  localparam logic [15:0] CRC_INIT   = 16'hFFFF;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [16:0] MAX_LEN_RESET = 17'd65543;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_BYTE  = 2'd1,
    REQ_IDLE  = 2'd2
  } req_t;

  typedef enum logic [3:0] {
    REG_APID        = 4'd0,
    REG_TYPE_FLAG   = 4'd1,
    REG_SEC_HDR     = 4'd2,
    REG_CRC_ENABLE  = 4'd3,
    REG_VERSION     = 4'd4,
    REG_MAX_LEN     = 4'd5,
    REG_RSVD_APID   = 4'd6,
    REG_SEC_HDR_MIN = 4'd7
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_SEC_SHORT  = 3'd1,
    ST_TOO_SMALL  = 3'd2,
    ST_NO_SPACE   = 3'd3,
    ST_VERSION    = 3'd4,
    ST_APID       = 3'd5
  } st_t;

  typedef enum logic [1:0] {
    CMD_ERR  = 2'd0,
    CMD_HDR  = 2'd1,
    CMD_BYTE = 2'd2
  } cmd_kind_t;

  typedef struct packed {
    logic [10:0] apid;
    logic        type_flag;
    logic        sec_hdr_present;
    logic        crc_enable;
    logic [2:0]  version;
    logic [16:0] max_packet_len;
    logic [10:0] reserved_apid;
    logic [7:0]  sec_hdr_min;
  } cfg_t;

  // One unit of work for the back end.
  typedef struct packed {
    cmd_kind_t       kind;
    st_t             st;     // error code for CMD_ERR
    logic [7:0]      data;   // payload byte for CMD_BYTE
    logic [5:0][7:0] hdr;    // primary header, byte 0 first
    logic            empty;  // header with no body
    logic            crc;    // trailer follows
    logic            tail;   // final payload byte
  } cmd_t;

  typedef struct packed {
    logic full;
    logic valid;
  } q_status_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0] b);
    logic [15:0] c;
    c = crc_in ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage

@@ rtl/space_packet_framer.sv @@
// Channel   Dir  Handshake           Payload
// in        in   in_valid/in_stall   req_type byte_value shdr_bytes user_bytes
//                                    seq_num seq_flags
// out       out  out_valid/out_stall out_byte status last
// cfg       in   cfg_valid/cfg_ready cfg_index cfg_data
//
// A payload byte item goes to the 4-entry command queue, then the output
// register; one output byte leaves per cycle while out_stall is low, so a
// header (6 bytes) or CRC trailer (2 bytes) holds intake once the queue fills.
// Reset is synchronous and active high; registers return to their reset
// values and the queue and output register empty. No clearing pass.
// in_stall depends only on queue fill; out_stall freezes the output register
// and the back end, not the front end.
module space_packet_framer
  import spf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input transactions
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  byte_value,
  input  logic [15:0] shdr_bytes,
  input  logic [15:0] user_bytes,
  input  logic [13:0] seq_num,
  input  logic [1:0]  seq_flags,
  // result transactions
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic [2:0]  status,
  output logic        last,
  // register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_index,
  input  logic [16:0] cfg_data
);

  cfg_t      cfg;
  q_status_t qs;
  cmd_t      push_cmd, head;
  logic      push, pop;

  // Registers take a write every cycle; indexes past the list are dropped.
  assign cfg_ready = 1'b1;

  spf_regs u_regs (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // Front: accept, run the start checks, track the open packet.
  spf_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .req_type    (req_type),
    .byte_value  (byte_value),
    .shdr_bytes  (shdr_bytes),
    .user_bytes  (user_bytes),
    .seq_num     (seq_num),
    .seq_flags   (seq_flags),
    .qs          (qs),
    .push        (push),
    .push_cmd    (push_cmd)
  );

  // Queue decouples the two sides.
  spf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .qs       (qs),
    .head     (head)
  );

  // Back: expand commands into bytes, run the CRC, hold the output register.
  spf_back u_back (
    .clk       (clk),
    .rst       (rst),
    .qs        (qs),
    .head      (head),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .status    (status),
    .last      (last)
  );

endmodule

@@ rtl/spf_regs.sv @@
module spf_regs
  import spf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        wr_en,
  input  logic [3:0]  wr_index,
  input  logic [16:0] wr_data,
  output cfg_t        cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.apid            <= '0;
      cfg.type_flag       <= 1'b0;
      cfg.sec_hdr_present <= 1'b0;
      cfg.crc_enable      <= 1'b0;
      cfg.version         <= '0;
      cfg.max_packet_len  <= MAX_LEN_RESET;
      cfg.reserved_apid   <= '0;
      cfg.sec_hdr_min     <= 8'd1;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_APID:        cfg.apid            <= wr_data[10:0];
        REG_TYPE_FLAG:   cfg.type_flag       <= wr_data[0];
        REG_SEC_HDR:     cfg.sec_hdr_present <= wr_data[0];
        REG_CRC_ENABLE:  cfg.crc_enable      <= wr_data[0];
        REG_VERSION:     cfg.version         <= wr_data[2:0];
        REG_MAX_LEN:     cfg.max_packet_len  <= wr_data;
        REG_RSVD_APID:   cfg.reserved_apid   <= wr_data[10:0];
        REG_SEC_HDR_MIN: cfg.sec_hdr_min     <= wr_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

@@ rtl/spf_front.sv @@
module spf_front
  import spf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [7:0]  byte_value,
  input  logic [15:0] shdr_bytes,
  input  logic [15:0] user_bytes,
  input  logic [13:0] seq_num,
  input  logic [1:0]  seq_flags,
  input  q_status_t   qs,
  output logic        push,
  output cmd_t        push_cmd
);

  logic        packet_open;
  logic [16:0] bytes_left;
  logic        crc_on;

  logic        accept, is_start, is_idle, is_byte, open_req;
  logic [10:0] ap;
  logic        ty, sh, crc;
  logic [2:0]  ver;
  logic [1:0]  flags;
  logic [15:0] shlen_eff, dlen_eff;
  logic [16:0] payload;
  logic [17:0] total;
  logic [15:0] plen;
  st_t         st;

  assign in_stall = qs.full;
  assign accept   = in_valid && !qs.full;
  assign is_start = (req_type == REQ_START);
  assign is_idle  = (req_type == REQ_IDLE);
  assign is_byte  = (req_type == REQ_BYTE);
  assign open_req = (is_start || is_idle) && !packet_open;

  always_comb begin
    ap        = is_idle ? IDLE_APID : cfg.apid;
    ty        = is_idle ? 1'b0 : cfg.type_flag;
    sh        = is_idle ? 1'b0 : cfg.sec_hdr_present;
    crc       = is_idle ? 1'b1 : cfg.crc_enable;
    ver       = is_idle ? 3'd0 : cfg.version;
    flags     = is_idle ? IDLE_FLAGS : seq_flags;
    shlen_eff = sh ? shdr_bytes : 16'd0;
    dlen_eff  = is_idle ? 16'd0 : user_bytes;
    payload   = {1'b0, shlen_eff} + {1'b0, dlen_eff};
    total     = {1'b0, payload} + 18'(HDR_BYTES) + (crc ? 18'd2 : 18'd0);
    plen      = 16'(total - 18'(HDR_BYTES + 1));

    // Checks in priority order.
    if (sh && (shdr_bytes < {8'd0, cfg.sec_hdr_min})) st = ST_SEC_SHORT;
    else if (total < 18'(MIN_PACKET_BYTES))            st = ST_TOO_SMALL;
    else if ((total > {1'b0, cfg.max_packet_len}) || (total > 18'(LEN_LIMIT)))
                                                       st = ST_NO_SPACE;
    else if (ver != 3'd0)                              st = ST_VERSION;
    else if (ap == cfg.reserved_apid)                  st = ST_APID;
    else                                               st = ST_OK;

    push_cmd.kind  = is_byte ? CMD_BYTE : ((st == ST_OK) ? CMD_HDR : CMD_ERR);
    push_cmd.st    = st;
    push_cmd.data  = byte_value;
    push_cmd.hdr[0] = {ver, ty, sh, ap[10:8]};
    push_cmd.hdr[1] = ap[7:0];
    push_cmd.hdr[2] = {flags, seq_num[13:8]};
    push_cmd.hdr[3] = seq_num[7:0];
    push_cmd.hdr[4] = plen[15:8];
    push_cmd.hdr[5] = plen[7:0];
    push_cmd.empty = (payload == 17'd0);
    push_cmd.crc   = is_byte ? crc_on : crc;
    push_cmd.tail  = (bytes_left == 17'd1);
  end

  // Stray bytes, opens during a packet and unknown codes are dropped here.
  assign push = accept && (open_req || (is_byte && packet_open));

  always_ff @(posedge clk) begin
    if (rst) begin
      packet_open <= 1'b0;
      bytes_left  <= '0;
      crc_on      <= 1'b0;
    end else if (accept) begin
      if (open_req && (st == ST_OK) && (payload != 17'd0)) begin
        packet_open <= 1'b1;
        bytes_left  <= payload;
        crc_on      <= crc;
      end else if (is_byte && packet_open) begin
        bytes_left <= bytes_left - 17'd1;
        if (bytes_left == 17'd1) begin
          packet_open <= 1'b0;
        end
      end
    end
  end

endmodule

@@ rtl/spf_queue.sv @@
module spf_queue
  import spf_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  cmd_t      push_cmd,
  input  logic      pop,
  output q_status_t qs,
  output cmd_t      head
);

  cmd_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign qs.full  = (count == QCNT_W'(QDEPTH));
  assign qs.valid = (count != '0);
  assign head     = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop)      count <= count + QCNT_W'(1);
      else if (pop && !push) count <= count - QCNT_W'(1);
    end
  end

endmodule

@@ rtl/spf_back.sv @@
module spf_back
  import spf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  q_status_t  qs,
  input  cmd_t       head,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic [2:0] status,
  output logic       last
);

  logic [2:0]  step, step_next;
  logic [15:0] crc, crc_next;
  logic [7:0]  byte_next;
  st_t         st_next;
  logic        last_next, done, adv;

  assign adv = !out_valid || !out_stall;
  assign pop = adv && qs.valid && done;

  always_comb begin
    byte_next = 8'd0;
    st_next   = ST_OK;
    last_next = 1'b0;
    done      = 1'b0;
    crc_next  = crc;
    case (head.kind)
      CMD_ERR: begin
        st_next   = head.st;
        last_next = 1'b1;
        done      = 1'b1;
      end
      CMD_HDR: begin
        if (step < 3'd6) begin
          byte_next = head.hdr[step];
          crc_next  = crc16_byte((step == 3'd0) ? CRC_INIT : crc, byte_next);
          last_next = (step == 3'd5) && head.empty && !head.crc;
          done      = (step == 3'd5) && !(head.empty && head.crc);
        end else if (step == 3'd6) begin
          byte_next = crc[15:8];
        end else begin
          byte_next = crc[7:0];
          last_next = 1'b1;
          done      = 1'b1;
        end
      end
      CMD_BYTE: begin
        if (step == 3'd0) begin
          byte_next = head.data;
          crc_next  = crc16_byte(crc, head.data);
          last_next = head.tail && !head.crc;
          done      = !(head.tail && head.crc);
        end else if (step == 3'd1) begin
          byte_next = crc[15:8];
        end else begin
          byte_next = crc[7:0];
          last_next = 1'b1;
          done      = 1'b1;
        end
      end
      default: done = 1'b1;
    endcase
    step_next = done ? 3'd0 : step + 3'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
      crc       <= CRC_INIT;
    end else if (adv) begin
      out_valid <= qs.valid;
      if (qs.valid) begin
        step <= step_next;
        crc  <= crc_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv && qs.valid) begin
      out_byte <= byte_next;
      status   <= st_next;
      last     <= last_next;
    end
  end

endmodule

@@ rtl/spf_checker.sv @@
module spf_checker
  import spf_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [7:0]  out_byte,
  input logic [2:0]  status,
  input logic        last
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output valid after reset");

  a_err_shape: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (status != ST_OK)) |-> (last && (out_byte == 8'd0)))
    else $error("error result not a single zero byte marked last");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status <= ST_APID))
    else $error("status code out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=>
      (out_valid && $stable(out_byte) && $stable(status) && $stable(last)))
    else $error("stalled result changed");

endmodule

bind space_packet_framer spf_checker u_spf_checker (.*);
